@@ rtl/pwm_duty_period_capture_top_defines.svh @@
// Assertion macros for the PWM duty/period capture block.
// Used by pwm_duty_period_capture_top; no other dependencies.
`ifndef PWM_DUTY_PERIOD_CAPTURE_TOP_DEFINES_SVH
`define PWM_DUTY_PERIOD_CAPTURE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PDPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pdpc assertion failed");
// next-cycle implication
`define PDPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pdpc assertion failed");
`else
`define PDPC_ASSERT_IMP(lbl, ante, cons)
`define PDPC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ rtl/pdpc_pkg.sv @@
// Shared types and constants of the PWM duty/period capture block.
// No dependencies; used by pdpc_div and pwm_duty_period_capture_top.
package pdpc_pkg;

  localparam int unsigned CapW  = 16;
  localparam int unsigned OvfW  = 16;
  localparam int unsigned TickW = 32;
  localparam int unsigned DutyW = 16;

  localparam logic CmdOverflow = 1'b0;
  localparam logic CmdCapture  = 1'b1;

  localparam logic EdgeFalling = 1'b0;
  localparam logic EdgeRising  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_XFER
  } ctrl_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic              measurement_valid;
    logic              measure_error;
    logic [DutyW-1:0]  duty_fraction;
    logic [TickW-1:0]  period_ticks;
    logic [TickW-1:0]  first_interval_ticks;
    logic              stop_and_clear;
    logic              next_edge_rising;
  } result_t;

endpackage

@@ rtl/pdpc_div.sv @@
// Bit-serial restoring divider for the duty fraction, one quotient bit per cycle.
// Depends on pdpc_pkg.
module pdpc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pdpc_pkg::TickW-1:0]  dividend_i,
  input  logic [pdpc_pkg::TickW-1:0]  divisor_i,
  output pdpc_pkg::div_stat_t         stat_o,
  output logic [pdpc_pkg::DutyW-1:0]  duty_o
);

  localparam int unsigned Fb   = pdpc_pkg::DutyW;
  localparam int unsigned TW   = pdpc_pkg::TickW;
  localparam int unsigned CntW = $clog2(Fb + 1);

  logic [TW:0]    rem_q, rem_d;
  logic [TW-1:0]  den_q, den_d;
  logic [Fb:0]    quo_q, quo_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           done_q, done_d;

  logic [TW+1:0]  trial;
  logic           ge;
  logic [TW:0]    rem_sel;
  logic [Fb-1:0]  sat;

  assign trial   = {1'b0, rem_q} - {2'b00, den_q};
  assign ge      = ~trial[TW+1];
  assign rem_sel = ge ? trial[TW:0] : rem_q;

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = {1'b0, dividend_i};
      den_d  = divisor_i;
      quo_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in one quotient bit, double the partial remainder
      quo_d = {quo_q[Fb-1:0], ge};
      rem_d = {rem_sel[TW-1:0], 1'b0};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(Fb)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  // a quotient of exactly one saturates to all ones
  assign sat    = quo_q[Fb] ? '1 : quo_q[Fb-1:0];
  assign duty_o = sat;

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ rtl/pwm_duty_period_capture_top.sv @@
// PWM duty/period capture: a timer-event sequencer with a bit-serial duty divider.
// Depends on pdpc_pkg, pdpc_div and pwm_duty_period_capture_top_defines.svh.
//
// Each input beat is a timer event (tuser: 0 overflow, 1 edge capture) and
// yields exactly one output beat. Overflow events, ignored captures, the
// first capture of a cycle and a closing capture flagged as an error have
// their result registered and then moved to the output register once it
// frees. A closing capture without error first runs through the restoring
// divider, which produces one quotient bit per cycle, before its result moves
// on. A new event is accepted as soon as the previous result has moved to the
// output register, so one finished result may wait on the output while the
// next event is taken; a second finished result holds off the input until
// the output drains.
// Period is reported in timer ticks; conversion to seconds is left to software.
`include "pwm_duty_period_capture_top_defines.svh"

module pwm_duty_period_capture_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] capture_value, [16] timer_running, [23:17] zero
  input  logic [23:0] s_axis_tdata_i,
  // [0] cmd
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] next_edge_rising, [1] stop_and_clear, [33:2] first_interval_ticks,
  // [65:34] period_ticks, [81:66] duty_fraction, [82] measure_error, [87:83] zero
  output logic [87:0] m_axis_tdata_o,
  // [0] measurement_valid
  output logic        m_axis_tuser_o
);

  localparam int unsigned TW = pdpc_pkg::TickW;

  pdpc_pkg::ctrl_state_e state_q, state_d;
  logic [pdpc_pkg::OvfW-1:0] ovf_q, ovf_d;
  logic                      second_q, second_d;
  logic [TW-1:0]             first_q, first_d;
  logic                      edge_q, edge_d;
  pdpc_pkg::result_t         res_q, res_d;
  pdpc_pkg::result_t         out_q, out_d;
  logic                      out_valid_q, out_valid_d;

  logic                      accept;
  logic [pdpc_pkg::CapW-1:0] cap;
  logic                      running;
  logic [63:0]               hi_wide;
  logic [TW-1:0]             ext;
  logic                      div_start;
  logic [TW-1:0]             diff;
  pdpc_pkg::div_stat_t       div_stat;
  logic [pdpc_pkg::DutyW-1:0] div_duty;

  assign cap     = s_axis_tdata_i[15:0];
  assign running = s_axis_tdata_i[16];
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == pdpc_pkg::ST_IDLE);

  // extend the capture with the overflow count, wrapping at 32 bits
  assign hi_wide = 64'(ovf_q) << pdpc_pkg::CapW;
  assign ext     = hi_wide[TW-1:0] + TW'(cap);
  assign diff    = ext - first_q;

  always_comb begin
    state_d     = state_q;
    ovf_d       = ovf_q;
    second_d    = second_q;
    first_d     = first_q;
    edge_d      = edge_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    div_start   = 1'b0;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      pdpc_pkg::ST_IDLE: begin
        if (accept) begin
          res_d   = '0;
          state_d = pdpc_pkg::ST_XFER;
          if (s_axis_tuser_i == pdpc_pkg::CmdOverflow) begin
            ovf_d = ovf_q + 1'b1;
          end else if (running) begin
            if (!second_q) begin
              first_d  = ext;
              edge_d   = pdpc_pkg::EdgeFalling;
              second_d = 1'b1;
            end else begin
              res_d.period_ticks      = ext;
              res_d.measurement_valid = 1'b1;
              res_d.stop_and_clear    = 1'b1;
              edge_d   = pdpc_pkg::EdgeRising;
              second_d = 1'b0;
              ovf_d    = '0;
              if (ext == '0 || first_q > ext) begin
                res_d.measure_error = 1'b1;
              end else begin
                div_start = 1'b1;
                state_d   = pdpc_pkg::ST_DIV;
              end
            end
          end
          res_d.next_edge_rising     = edge_d;
          res_d.first_interval_ticks = first_d;
        end
      end
      pdpc_pkg::ST_DIV: begin
        if (div_stat.done) begin
          res_d.duty_fraction = div_duty;
          state_d = pdpc_pkg::ST_XFER;
        end
      end
      pdpc_pkg::ST_XFER: begin
        // hand the result over once the output register frees
        if (!out_valid_q || m_axis_tready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = pdpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pdpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pdpc_pkg::ST_IDLE;
      ovf_q       <= '0;
      second_q    <= 1'b0;
      first_q     <= '0;
      edge_q      <= pdpc_pkg::EdgeRising;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ovf_q       <= ovf_d;
      second_q    <= second_d;
      first_q     <= first_d;
      edge_q      <= edge_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  pdpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff),
    .divisor_i  (ext),
    .stat_o     (div_stat),
    .duty_o     (div_duty)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.measurement_valid;
  assign m_axis_tdata_o  = {5'b00000, out_q.measure_error, out_q.duty_fraction,
                            out_q.period_ticks, out_q.first_interval_ticks,
                            out_q.stop_and_clear, out_q.next_edge_rising};

  `PDPC_ASSERT_IMP(a_div_done_in_div, div_stat.done, state_q == pdpc_pkg::ST_DIV)
  `PDPC_ASSERT_NXT(a_start_enters_div, div_start, div_stat.busy && state_q == pdpc_pkg::ST_DIV)
  `PDPC_ASSERT_IMP(a_meas_stops_rising, m_axis_tvalid_o && out_q.measurement_valid,
                   out_q.stop_and_clear && out_q.next_edge_rising)
  `PDPC_ASSERT_IMP(a_err_zero_duty, m_axis_tvalid_o && out_q.measure_error,
                   out_q.duty_fraction == '0 && out_q.measurement_valid)

endmodule

@@ tb/pwm_duty_period_capture_top_tb.sv @@
// Self-checking testbench for pwm_duty_period_capture_top: timer-event stream in,
// one measurement beat out per event, checked against an in-bench duty/period model.
// Depends on pdpc_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module pwm_duty_period_capture_top_tb;

  localparam int unsigned DrainCycles = 32;
  localparam int unsigned CapW  = pdpc_pkg::CapW;
  localparam int unsigned OvfW  = pdpc_pkg::OvfW;
  localparam int unsigned TickW = pdpc_pkg::TickW;
  localparam int unsigned DutyW = pdpc_pkg::DutyW;

  typedef pdpc_pkg::result_t result_t;

  // Expected results plus the running state of the capture sequencer.
  class capture_scoreboard;
    result_t         want_q[$];
    logic            awaiting_period;
    logic [OvfW-1:0] ovf_cnt;
    logic [TickW-1:0] first_ticks;
    logic            edge_sel;
    int unsigned     n_bad;
    int unsigned     n_events;
    int unsigned     n_measured;
    int unsigned     n_flagged;
    int unsigned     n_skipped;
    int unsigned     n_saturated;

    function new();
      awaiting_period = 1'b0;
      ovf_cnt         = '0;
      first_ticks     = '0;
      edge_sel        = pdpc_pkg::EdgeRising;
      n_bad           = 0;
      n_events        = 0;
      n_measured      = 0;
      n_flagged       = 0;
      n_skipped       = 0;
      n_saturated     = 0;
    endfunction

    function logic [DutyW-1:0] duty_of(logic [TickW-1:0] first,
                                       logic [TickW-1:0] period);
      logic [63:0] quo;
      quo = ({32'b0, period - first} << DutyW) / {32'b0, period};
      if (quo > 64'(2**DutyW - 1)) begin
        n_saturated++;
        return '1;
      end
      return quo[DutyW-1:0];
    endfunction

    // Advance the model by one accepted event and queue its result.
    function void note_event(logic cmd, logic [CapW-1:0] cap, logic running);
      result_t      r;
      logic [TickW-1:0] ext;
      r = '0;
      n_events++;
      if (cmd == pdpc_pkg::CmdOverflow) begin
        ovf_cnt = ovf_cnt + 1'b1;
      end else if (running) begin
        ext = {ovf_cnt, cap};
        if (!awaiting_period) begin
          first_ticks     = ext;
          edge_sel        = pdpc_pkg::EdgeFalling;
          awaiting_period = 1'b1;
        end else begin
          r.period_ticks      = ext;
          r.measurement_valid = 1'b1;
          if (ext == '0 || first_ticks > ext) begin
            r.measure_error = 1'b1;
            n_flagged++;
          end else begin
            r.duty_fraction = duty_of(first_ticks, ext);
          end
          r.stop_and_clear = 1'b1;
          edge_sel         = pdpc_pkg::EdgeRising;
          awaiting_period  = 1'b0;
          ovf_cnt          = '0;
          n_measured++;
        end
      end else begin
        n_skipped++;
      end
      r.next_edge_rising     = edge_sel;
      r.first_interval_ticks = first_ticks;
      want_q.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      n_bad++;
    endtask

    task check(result_t got);
      result_t exp;
      if (want_q.size() == 0) begin
        report("output beat with no event pending");
        return;
      end
      exp = want_q.pop_front();
      if (got.measurement_valid !== exp.measurement_valid)
        report($sformatf("measurement_valid %0b, want %0b",
                         got.measurement_valid, exp.measurement_valid));
      if (got.next_edge_rising !== exp.next_edge_rising)
        report($sformatf("next_edge_rising %0b, want %0b",
                         got.next_edge_rising, exp.next_edge_rising));
      if (got.stop_and_clear !== exp.stop_and_clear)
        report($sformatf("stop_and_clear %0b, want %0b",
                         got.stop_and_clear, exp.stop_and_clear));
      if (got.first_interval_ticks !== exp.first_interval_ticks)
        report($sformatf("first_interval_ticks %h, want %h",
                         got.first_interval_ticks, exp.first_interval_ticks));
      if (got.period_ticks !== exp.period_ticks)
        report($sformatf("period_ticks %h, want %h",
                         got.period_ticks, exp.period_ticks));
      if (got.duty_fraction !== exp.duty_fraction)
        report($sformatf("duty_fraction %h, want %h",
                         got.duty_fraction, exp.duty_fraction));
      if (got.measure_error !== exp.measure_error)
        report($sformatf("measure_error %0b, want %0b",
                         got.measure_error, exp.measure_error));
    endtask

    function int unsigned pending();
      return want_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [87:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  capture_scoreboard sb = new();

  bit          idle_en      = 1'b1;
  bit          hold_armed   = 1'b0;
  int unsigned n_live       = 0;

  pwm_duty_period_capture_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("Regression FAIL");
    $finish;
  end

  // Output sink: random stall bursts, plus one long hold-off to back up the input.
  initial begin
    int unsigned stall_left;
    bit          held;
    stall_left      = 0;
    held            = 1'b0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_armed && !held) begin
        held       = 1'b1;
        stall_left = 120;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.next_edge_rising     = m_axis_tdata_o[0];
      got.stop_and_clear       = m_axis_tdata_o[1];
      got.first_interval_ticks = m_axis_tdata_o[33:2];
      got.period_ticks         = m_axis_tdata_o[65:34];
      got.duty_fraction        = m_axis_tdata_o[81:66];
      got.measure_error        = m_axis_tdata_o[82];
      got.measurement_valid    = m_axis_tuser_o;
      sb.check(got);
    end
  end

  // Offer one event beat and hold it until the block takes it.
  task automatic send_event(logic cmd, logic [CapW-1:0] cap, logic running);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'b0, running, cap};
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_event(cmd, cap, running);
    n_live++;
  endtask

  task automatic send_overflow();
    send_event(pdpc_pkg::CmdOverflow, CapW'($urandom_range(0, 65535)),
               1'($urandom_range(0, 1)));
  endtask

  function automatic logic [CapW-1:0] pick_cap();
    unique case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CapW'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic run_random(int unsigned target);
    int unsigned stop_at;
    stop_at = n_live + target;
    while (n_live < stop_at) begin
      // drop idling for the tail of the run
      if (n_live + 100 >= stop_at)
        idle_en = 1'b0;
      if ($urandom_range(0, 9) < 7) begin
        repeat ($urandom_range(0, 2)) send_overflow();
        if ($urandom_range(0, 5) == 0)
          send_event(pdpc_pkg::CmdCapture, pick_cap(), 1'b0);
        send_event(pdpc_pkg::CmdCapture, pick_cap(), 1'b1);
        repeat ($urandom_range(0, 3)) send_overflow();
        if ($urandom_range(0, 5) == 0)
          send_event(pdpc_pkg::CmdCapture, pick_cap(), 1'b0);
        send_event(pdpc_pkg::CmdCapture, pick_cap(), 1'b1);
      end else begin
        send_event(1'($urandom_range(0, 1)), pick_cap(), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = pdpc_pkg::CmdOverflow;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: ignored captures, zero first interval, zero/short period, equal edges.
    send_event(pdpc_pkg::CmdOverflow, 16'hFFFF, 1'b1);
    send_event(pdpc_pkg::CmdCapture, 16'hFFFF, 1'b0);
    send_event(pdpc_pkg::CmdCapture, 16'h0000, 1'b1);
    send_event(pdpc_pkg::CmdOverflow, 16'h0000, 1'b0);
    send_event(pdpc_pkg::CmdCapture, 16'h8000, 1'b1);
    send_event(pdpc_pkg::CmdCapture, 16'h0000, 1'b1);
    send_event(pdpc_pkg::CmdCapture, 16'h0000, 1'b1);
    send_event(pdpc_pkg::CmdOverflow, 16'h5555, 1'b1);
    send_event(pdpc_pkg::CmdOverflow, 16'hAAAA, 1'b0);
    send_event(pdpc_pkg::CmdCapture, 16'h4000, 1'b1);
    send_event(pdpc_pkg::CmdCapture, 16'h0100, 1'b0);
    send_event(pdpc_pkg::CmdCapture, 16'h0100, 1'b1);
    send_event(pdpc_pkg::CmdCapture, 16'h1000, 1'b1);
    send_event(pdpc_pkg::CmdOverflow, 16'h0000, 1'b0);
    send_event(pdpc_pkg::CmdCapture, 16'h1000, 1'b1);
    send_event(pdpc_pkg::CmdCapture, 16'h00FF, 1'b1);
    send_event(pdpc_pkg::CmdCapture, 16'h00FF, 1'b1);
    send_event(pdpc_pkg::CmdCapture, 16'h0001, 1'b1);
    send_event(pdpc_pkg::CmdCapture, 16'hFFFF, 1'b1);

    hold_armed = 1'b1;
    run_random(680);
    s_axis_tvalid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d events sent (%0d stopped captures skipped), %0d periods measured",
             sb.n_events, sb.n_skipped, sb.n_measured);
    $display("%0d flagged as zero or short period, %0d duty values saturated",
             sb.n_flagged, sb.n_saturated);
    if (sb.n_bad == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
